@@ src/arkf_pkg.sv @@
// ----------------------------------------------------------------------------
// Angle/rate Kalman filter package
// Shared types, constants and the microcode table of the filter core.
// ----------------------------------------------------------------------------
package arkf_pkg;

  localparam int FRAC_BITS = 20;
  localparam int COV_W     = 48;
  localparam int ST_W      = 32;
  localparam int STEP_W    = 24;
  localparam int CFG_W     = 32;
  localparam int OPD_W     = COV_W + 1;
  localparam int SUM_W     = OPD_W + 1;
  localparam int ERR_W     = ST_W + 1;
  localparam int MAG_W     = COV_W;
  localparam int CHUNK_W   = 16;
  localparam int PROD_W    = 2 * MAG_W;
  localparam int DIV_STEPS = COV_W + FRAC_BITS;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);
  localparam int QDEPTH    = 2;
  localparam int QPTR_W    = $clog2(QDEPTH);
  localparam int QCNT_W    = $clog2(QDEPTH + 1);
  localparam int PC_W      = 4;

  localparam logic [PC_W-1:0] PC_DIV       = PC_W'(6);
  localparam logic [PC_W-1:0] PC_CORR_LAST = PC_W'(12);
  localparam logic [PC_W-1:0] PC_PRED      = PC_W'(13);

  localparam logic signed [ST_W-1:0] INIT_ANGLE =
    ST_W'(((longint'(1) << FRAC_BITS) + 5) / 10);
  localparam logic signed [ST_W-1:0] INIT_RATE =
    ST_W'(((longint'(2) << FRAC_BITS) + 5) / 10);

  localparam logic [CFG_W-1:0] Q_ANGLE_RST = CFG_W'(10 << FRAC_BITS);
  localparam logic [CFG_W-1:0] Q_RATE_RST  = CFG_W'(8 << FRAC_BITS);
  localparam logic [CFG_W-1:0] R_MEAS_RST  = CFG_W'(1 << (FRAC_BITS - 1));

  typedef logic signed [COV_W-1:0] cov_t;
  typedef logic signed [OPD_W-1:0] opd_t;

  typedef enum logic [1:0] {
    OP_ADVANCE = 2'd0,
    OP_PEEK    = 2'd1,
    OP_CORRECT = 2'd2,
    OP_RESTART = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    CFG_Q_ANGLE = 2'd0,
    CFG_Q_RATE  = 2'd1,
    CFG_R_MEAS  = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [1:0]             req_type;
    logic [STEP_W-1:0]      step_time;
    logic signed [ST_W-1:0] measured_angle;
  } in_item_t;

  typedef struct packed {
    logic signed [ST_W-1:0] angle_out;
    logic signed [ST_W-1:0] rate_out;
    logic                   saturated;
  } out_item_t;

  typedef struct packed {
    op_e                    op;
    logic [STEP_W-1:0]      step;
    logic signed [ST_W-1:0] meas;
  } cmd_t;

  typedef struct packed {
    logic start;
    opd_t a;
    opd_t b;
  } mul_req_t;

  typedef struct packed {
    logic done;
    cov_t res;
    logic sat;
  } mul_rsp_t;

  typedef struct packed {
    logic start;
    cov_t num;
    cov_t den;
  } div_req_t;

  typedef struct packed {
    logic done;
    cov_t res;
    logic sat;
  } div_rsp_t;

  typedef enum logic [4:0] {
    SRC_P00, SRC_P01, SRC_P10, SRC_P11,
    SRC_TA, SRC_TB, SRC_TC, SRC_TD, SRC_TS,
    SRC_K0, SRC_K1, SRC_ERR, SRC_ANG, SRC_RATE,
    SRC_DT, SRC_STEP, SRC_QA, SRC_QR, SRC_RM, SRC_ONE
  } src_e;

  typedef enum logic [3:0] {
    DST_TA, DST_TB, DST_TC, DST_TD, DST_TS,
    DST_ANG, DST_RATE, DST_P00, DST_P01, DST_P10, DST_P11
  } dst_e;

  // One microinstruction: dst = sat(w +/- ((a * b) >> FRAC_BITS)).
  typedef struct packed {
    src_e a;
    src_e b;
    src_e w;
    logic sub;
    logic narrow;
    dst_e dst;
  } uop_t;

  typedef enum logic [2:0] {
    BE_IDLE,
    BE_MUL_GO,
    BE_MUL_WAIT,
    BE_ADD,
    BE_DIV_GO,
    BE_DIV_WAIT,
    BE_DONE
  } be_state_e;

  function automatic uop_t uop_at(input logic [PC_W-1:0] pc);
    uop_t u;
    case (pc)
      4'd0:    u = '{SRC_DT,   SRC_P10,  SRC_P00,  1'b0, 1'b0, DST_TA};
      4'd1:    u = '{SRC_DT,   SRC_P11,  SRC_P01,  1'b0, 1'b0, DST_TB};
      4'd2:    u = '{SRC_DT,   SRC_TB,   SRC_TA,   1'b0, 1'b0, DST_TA};
      4'd3:    u = '{SRC_QA,   SRC_ONE,  SRC_TA,   1'b0, 1'b0, DST_TA};
      4'd4:    u = '{SRC_DT,   SRC_P11,  SRC_P10,  1'b0, 1'b0, DST_TC};
      4'd5:    u = '{SRC_QR,   SRC_ONE,  SRC_P11,  1'b0, 1'b0, DST_TD};
      4'd6:    u = '{SRC_RM,   SRC_ONE,  SRC_TA,   1'b0, 1'b0, DST_TS};
      4'd7:    u = '{SRC_K0,   SRC_ERR,  SRC_ANG,  1'b0, 1'b1, DST_ANG};
      4'd8:    u = '{SRC_K1,   SRC_ERR,  SRC_RATE, 1'b0, 1'b1, DST_RATE};
      4'd9:    u = '{SRC_K0,   SRC_TA,   SRC_TA,   1'b1, 1'b0, DST_P00};
      4'd10:   u = '{SRC_K0,   SRC_TB,   SRC_TB,   1'b1, 1'b0, DST_P01};
      4'd11:   u = '{SRC_K1,   SRC_TA,   SRC_TC,   1'b1, 1'b0, DST_P10};
      4'd12:   u = '{SRC_K1,   SRC_TB,   SRC_TD,   1'b1, 1'b0, DST_P11};
      default: u = '{SRC_STEP, SRC_RATE, SRC_ANG,  1'b0, 1'b1, DST_TA};
    endcase
    return u;
  endfunction

endpackage

@@ src/arkf_front.sv @@
// ----------------------------------------------------------------------------
// Angle/rate Kalman filter front end
// Accepts request items, decodes them and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module arkf_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  arkf_pkg::in_item_t in_data_i,
  output logic              cmd_valid_o,
  input  logic              cmd_ready_i,
  output arkf_pkg::cmd_t    cmd_o
);
  import arkf_pkg::*;

  cmd_t              slots_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] count_q, count_d;
  cmd_t              cmd_new;
  logic              push, pop;

  // Unused fields of a request are dropped here.
  always_comb begin
    cmd_new.op   = op_e'(in_data_i.req_type);
    cmd_new.step = '0;
    cmd_new.meas = '0;
    if (cmd_new.op == OP_ADVANCE || cmd_new.op == OP_PEEK) begin
      cmd_new.step = in_data_i.step_time;
    end
    if (cmd_new.op == OP_CORRECT) begin
      cmd_new.meas = in_data_i.measured_angle;
    end
  end

  assign in_ready_o  = (count_q != QCNT_W'(QDEPTH));
  assign cmd_valid_o = (count_q != '0);
  assign cmd_o       = slots_q[rd_ptr_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = cmd_valid_o && cmd_ready_i;

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q + QCNT_W'(push) - QCNT_W'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slots_q[wr_ptr_q] <= cmd_new;
    end
  end

endmodule

@@ src/arkf_mul.sv @@
// ----------------------------------------------------------------------------
// Angle/rate Kalman filter multiplier
// Sign-magnitude 48x48 multiply in three 48x16 steps, scaled and saturated.
// ----------------------------------------------------------------------------
module arkf_mul (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  arkf_pkg::mul_req_t req_i,
  output arkf_pkg::mul_rsp_t rsp_o
);
  import arkf_pkg::*;

  logic               busy_q, fin_q, done_q;
  logic [1:0]         cnt_q;
  logic               neg_q;
  logic [MAG_W-1:0]   ua_q, ub_q;
  logic [PROD_W-1:0]  acc_q;
  cov_t               res_q;
  logic               sat_q;
  opd_t               abs_a, abs_b;
  logic [CHUNK_W-1:0] chunk;
  logic [PROD_W-1:0]  pp, pp_sh, scaled, lim;
  logic [MAG_W-1:0]   mag;
  logic               ovf;

  assign abs_a = req_i.a[OPD_W-1] ? -req_i.a : req_i.a;
  assign abs_b = req_i.b[OPD_W-1] ? -req_i.b : req_i.b;

  always_comb begin
    case (cnt_q)
      2'd0:    chunk = ub_q[CHUNK_W-1:0];
      2'd1:    chunk = ub_q[2*CHUNK_W-1:CHUNK_W];
      default: chunk = ub_q[3*CHUNK_W-1:2*CHUNK_W];
    endcase
    pp = PROD_W'(ua_q * chunk);
    case (cnt_q)
      2'd0:    pp_sh = pp;
      2'd1:    pp_sh = pp << CHUNK_W;
      default: pp_sh = pp << (2 * CHUNK_W);
    endcase
  end

  // Final scaling: truncate toward zero, then clamp the magnitude.
  always_comb begin
    scaled = acc_q >> FRAC_BITS;
    lim    = (PROD_W'(1) << (COV_W - 1)) - PROD_W'(!neg_q);
    ovf    = scaled > lim;
    mag    = ovf ? lim[MAG_W-1:0] : scaled[MAG_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      fin_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= fin_q;
      fin_q  <= busy_q && (cnt_q == 2'd2);
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        busy_q <= (cnt_q != 2'd2);
        cnt_q  <= cnt_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      ua_q  <= abs_a[MAG_W-1:0];
      ub_q  <= abs_b[MAG_W-1:0];
      neg_q <= req_i.a[OPD_W-1] ^ req_i.b[OPD_W-1];
      acc_q <= '0;
    end else if (busy_q) begin
      acc_q <= acc_q + pp_sh;
    end
    if (fin_q) begin
      res_q <= neg_q ? -cov_t'(mag) : cov_t'(mag);
      sat_q <= ovf;
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.res  = res_q;
  assign rsp_o.sat  = sat_q;

endmodule

@@ src/arkf_div.sv @@
// ----------------------------------------------------------------------------
// Angle/rate Kalman filter divider
// Restoring divide of (num << FRAC_BITS) by den, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module arkf_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  arkf_pkg::div_req_t req_i,
  output arkf_pkg::div_rsp_t rsp_o
);
  import arkf_pkg::*;

  logic                 busy_q, done_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic                 neg_q, zero_q, sat_q;
  logic [DIV_STEPS-1:0] num_q;
  logic [MAG_W-1:0]     ud_q, rem_q, q_q;
  cov_t                 abs_n, abs_d;
  logic [MAG_W:0]       rem_sh, q_sh, cap;
  logic                 ge, ovf;
  logic [MAG_W-1:0]     rem_d, q_d;

  assign abs_n = req_i.num[COV_W-1] ? -req_i.num : req_i.num;
  assign abs_d = req_i.den[COV_W-1] ? -req_i.den : req_i.den;

  always_comb begin
    rem_sh = {rem_q, num_q[DIV_STEPS-1]};
    ge     = rem_sh >= {1'b0, ud_q};
    rem_d  = ge ? MAG_W'(rem_sh - {1'b0, ud_q}) : rem_sh[MAG_W-1:0];
    q_sh   = {q_q, ge};
    cap    = ((MAG_W+1)'(1) << (COV_W - 1)) - (MAG_W+1)'(!neg_q);
    ovf    = q_sh > cap;
    q_d    = ovf ? cap[MAG_W-1:0] : q_sh[MAG_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == DIV_CNT_W'(1));
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= (req_i.den == '0) ? DIV_CNT_W'(1) : DIV_CNT_W'(DIV_STEPS);
      end else if (busy_q) begin
        busy_q <= (cnt_q != DIV_CNT_W'(1));
        cnt_q  <= cnt_q - DIV_CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      num_q  <= {abs_n, {FRAC_BITS{1'b0}}};
      ud_q   <= abs_d;
      rem_q  <= '0;
      q_q    <= '0;
      sat_q  <= 1'b0;
      neg_q  <= req_i.num[COV_W-1] ^ req_i.den[COV_W-1];
      zero_q <= (req_i.den == '0);
    end else if (busy_q) begin
      num_q <= num_q << 1;
      rem_q <= rem_d;
      q_q   <= q_d;
      sat_q <= sat_q | ovf;
    end
  end

  // A zero divisor yields a zero gain and flags saturation.
  assign rsp_o.done = done_q;
  assign rsp_o.res  = zero_q ? '0 : (neg_q ? -cov_t'(q_q) : cov_t'(q_q));
  assign rsp_o.sat  = sat_q | zero_q;

endmodule

@@ src/arkf_back.sv @@
// ----------------------------------------------------------------------------
// Angle/rate Kalman filter back end
// Microcoded sequencer holding the filter state and the result register.
// ----------------------------------------------------------------------------
module arkf_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cmd_valid_i,
  output logic                  cmd_ready_o,
  input  arkf_pkg::cmd_t        cmd_i,
  input  logic [arkf_pkg::CFG_W-1:0] q_angle_i,
  input  logic [arkf_pkg::CFG_W-1:0] q_rate_i,
  input  logic [arkf_pkg::CFG_W-1:0] r_meas_i,
  output arkf_pkg::mul_req_t    mul_req_o,
  input  arkf_pkg::mul_rsp_t    mul_rsp_i,
  output arkf_pkg::div_req_t    div_req_o,
  input  arkf_pkg::div_rsp_t    div_rsp_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output arkf_pkg::out_item_t   out_data_o
);
  import arkf_pkg::*;

  localparam logic signed [SUM_W-1:0] COV_HI = {{(SUM_W-COV_W+1){1'b0}}, {(COV_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] COV_LO = ~COV_HI;
  localparam logic signed [SUM_W-1:0] ST_HI  = {{(SUM_W-ST_W+1){1'b0}}, {(ST_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] ST_LO  = ~ST_HI;

  be_state_e              state_q, state_d;
  logic [PC_W-1:0]        pc_q, pc_d;
  logic                   div_sel_q, div_sel_d;
  op_e                    op_q, op_d;
  logic [STEP_W-1:0]      step_q, step_d, tstep_q, tstep_d;
  logic signed [ERR_W-1:0] err_q, err_d;
  logic                   sat_q, sat_d;
  logic signed [ST_W-1:0] ang_q, ang_d, rate_q, rate_d;
  cov_t                   p00_q, p00_d, p01_q, p01_d, p10_q, p10_d, p11_q, p11_d;
  cov_t                   ta_q, ta_d, tb_q, tb_d, tc_q, tc_d, td_q, td_d, ts_q, ts_d;
  cov_t                   k0_q, k0_d, k1_q, k1_d;
  logic                   out_valid_q, out_valid_d;
  out_item_t              out_q, out_d;
  uop_t                   u;
  logic signed [SUM_W-1:0] sum;
  cov_t                   fit;
  logic                   fit_ovf;
  logic                   out_free;

  function automatic opd_t pick(input src_e s);
    opd_t v;
    case (s)
      SRC_P00:  v = OPD_W'(p00_q);
      SRC_P01:  v = OPD_W'(p01_q);
      SRC_P10:  v = OPD_W'(p10_q);
      SRC_P11:  v = OPD_W'(p11_q);
      SRC_TA:   v = OPD_W'(ta_q);
      SRC_TB:   v = OPD_W'(tb_q);
      SRC_TC:   v = OPD_W'(tc_q);
      SRC_TD:   v = OPD_W'(td_q);
      SRC_TS:   v = OPD_W'(ts_q);
      SRC_K0:   v = OPD_W'(k0_q);
      SRC_K1:   v = OPD_W'(k1_q);
      SRC_ERR:  v = OPD_W'(err_q);
      SRC_ANG:  v = OPD_W'(ang_q);
      SRC_RATE: v = OPD_W'(rate_q);
      SRC_DT:   v = OPD_W'({1'b0, tstep_q});
      SRC_STEP: v = OPD_W'({1'b0, step_q});
      SRC_QA:   v = OPD_W'({1'b0, q_angle_i});
      SRC_QR:   v = OPD_W'({1'b0, q_rate_i});
      SRC_RM:   v = OPD_W'({1'b0, r_meas_i});
      SRC_ONE:  v = OPD_W'(1) <<< FRAC_BITS;
      default:  v = '0;
    endcase
    return v;
  endfunction

  assign u        = uop_at(pc_q);
  assign out_free = !out_valid_q || out_ready_i;

  // Add or subtract the scaled product, then clamp to the target width.
  always_comb begin
    sum = u.sub ? SUM_W'(pick(u.w)) - SUM_W'(mul_rsp_i.res)
                : SUM_W'(pick(u.w)) + SUM_W'(mul_rsp_i.res);
    fit_ovf = 1'b0;
    fit     = COV_W'(sum);
    if (u.narrow) begin
      if (sum > ST_HI) begin
        fit = COV_W'(ST_HI); fit_ovf = 1'b1;
      end else if (sum < ST_LO) begin
        fit = COV_W'(ST_LO); fit_ovf = 1'b1;
      end
    end else begin
      if (sum > COV_HI) begin
        fit = COV_W'(COV_HI); fit_ovf = 1'b1;
      end else if (sum < COV_LO) begin
        fit = COV_W'(COV_LO); fit_ovf = 1'b1;
      end
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      BE_IDLE: begin
        if (cmd_valid_i) begin
          state_d = (cmd_i.op == OP_RESTART) ? BE_DONE : BE_MUL_GO;
        end
      end
      BE_MUL_GO:   state_d = BE_MUL_WAIT;
      BE_MUL_WAIT: if (mul_rsp_i.done) state_d = BE_ADD;
      BE_ADD: begin
        if (pc_q == PC_DIV) begin
          state_d = BE_DIV_GO;
        end else if (pc_q == PC_CORR_LAST || pc_q == PC_PRED) begin
          state_d = BE_DONE;
        end else begin
          state_d = BE_MUL_GO;
        end
      end
      BE_DIV_GO:   state_d = BE_DIV_WAIT;
      BE_DIV_WAIT: if (div_rsp_i.done) state_d = div_sel_q ? BE_MUL_GO : BE_DIV_GO;
      BE_DONE:     if (out_free) state_d = BE_IDLE;
      default:     state_d = BE_IDLE;
    endcase
  end

  always_comb begin
    pc_d        = pc_q;
    div_sel_d   = div_sel_q;
    op_d        = op_q;
    step_d      = step_q;
    tstep_d     = tstep_q;
    err_d       = err_q;
    sat_d       = sat_q;
    ang_d       = ang_q;
    rate_d      = rate_q;
    p00_d       = p00_q;
    p01_d       = p01_q;
    p10_d       = p10_q;
    p11_d       = p11_q;
    ta_d        = ta_q;
    tb_d        = tb_q;
    tc_d        = tc_q;
    td_d        = td_q;
    ts_d        = ts_q;
    k0_d        = k0_q;
    k1_d        = k1_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_ready_o = 1'b0;
    mul_req_o   = '{start: 1'b0, a: pick(u.a), b: pick(u.b)};
    div_req_o   = '{start: 1'b0, num: (div_sel_q ? tc_q : ta_q), den: ts_q};
    case (state_q)
      BE_IDLE: begin
        cmd_ready_o = 1'b1;
        if (cmd_valid_i) begin
          op_d      = cmd_i.op;
          step_d    = cmd_i.step;
          sat_d     = 1'b0;
          div_sel_d = 1'b0;
          err_d     = ERR_W'(cmd_i.meas) - ERR_W'(ang_q);
          pc_d      = (cmd_i.op == OP_CORRECT) ? '0 : PC_PRED;
          if (cmd_i.op == OP_ADVANCE || cmd_i.op == OP_PEEK) begin
            tstep_d = cmd_i.step;
          end
        end
      end
      BE_MUL_GO: mul_req_o.start = 1'b1;
      BE_ADD: begin
        sat_d = sat_q | mul_rsp_i.sat | fit_ovf;
        pc_d  = pc_q + PC_W'(1);
        case (u.dst)
          DST_TA:   ta_d   = fit;
          DST_TB:   tb_d   = fit;
          DST_TC:   tc_d   = fit;
          DST_TD:   td_d   = fit;
          DST_TS:   ts_d   = fit;
          DST_ANG:  ang_d  = ST_W'(fit);
          DST_RATE: rate_d = ST_W'(fit);
          DST_P00:  p00_d  = fit;
          DST_P01:  p01_d  = fit;
          DST_P10:  p10_d  = fit;
          DST_P11:  p11_d  = fit;
          default:  ta_d   = fit;
        endcase
      end
      BE_DIV_GO: div_req_o.start = 1'b1;
      BE_DIV_WAIT: begin
        if (div_rsp_i.done) begin
          sat_d     = sat_q | div_rsp_i.sat;
          div_sel_d = 1'b1;
          if (div_sel_q) begin
            k1_d = div_rsp_i.res;
          end else begin
            k0_d = div_rsp_i.res;
          end
        end
      end
      BE_DONE: begin
        if (out_free) begin
          out_valid_d         = 1'b1;
          out_d.saturated     = sat_q;
          out_d.angle_out     = ang_q;
          out_d.rate_out      = rate_q;
          case (op_q)
            OP_ADVANCE: begin
              ang_d           = ST_W'(ta_q);
              out_d.angle_out = ST_W'(ta_q);
            end
            OP_PEEK: out_d.angle_out = ST_W'(ta_q);
            OP_RESTART: begin
              ang_d           = INIT_ANGLE;
              rate_d          = INIT_RATE;
              p00_d           = COV_W'({1'b0, q_angle_i});
              p01_d           = '0;
              p10_d           = '0;
              p11_d           = COV_W'({1'b0, q_rate_i});
              out_d.angle_out = INIT_ANGLE;
              out_d.rate_out  = INIT_RATE;
              out_d.saturated = 1'b0;
            end
            default: ;
          endcase
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BE_IDLE;
      out_valid_q <= 1'b0;
      ang_q       <= INIT_ANGLE;
      rate_q      <= INIT_RATE;
      p00_q       <= COV_W'({1'b0, Q_ANGLE_RST});
      p01_q       <= '0;
      p10_q       <= '0;
      p11_q       <= COV_W'({1'b0, Q_RATE_RST});
      tstep_q     <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      ang_q       <= ang_d;
      rate_q      <= rate_d;
      p00_q       <= p00_d;
      p01_q       <= p01_d;
      p10_q       <= p10_d;
      p11_q       <= p11_d;
      tstep_q     <= tstep_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pc_q      <= pc_d;
    div_sel_q <= div_sel_d;
    op_q      <= op_d;
    step_q    <= step_d;
    err_q     <= err_d;
    sat_q     <= sat_d;
    ta_q      <= ta_d;
    tb_q      <= tb_d;
    tc_q      <= tc_d;
    td_q      <= td_d;
    ts_q      <= ts_d;
    k0_q      <= k0_d;
    k1_q      <= k1_d;
    out_q     <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

@@ src/angle_rate_kalman_filter.sv @@
// ----------------------------------------------------------------------------
// Angle/rate Kalman filter
// Two-state constant-velocity Kalman filter in Q.20 fixed point.
// ----------------------------------------------------------------------------
// Each request item yields exactly one result item. The time a correct item
// takes is set by the shared 48x16 multiplier, used for each of its 13
// multiply-accumulate steps, and by the bit-serial divider, which runs
// once for each of the two gains. The front end queues up to two items,
// so requests can be posted while the core is busy, and a finished result
// waits in an output register without blocking the core from taking the
// next queued item. Configuration registers (q_angle, q_rate, r_meas) are
// always ready and must only be written while the filter is idle; a restart
// loads the covariance from the current q_angle and q_rate.
module angle_rate_kalman_filter (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  arkf_pkg::in_item_t          in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output arkf_pkg::out_item_t         out_data_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [1:0]                  cfg_index_i,
  input  logic [arkf_pkg::CFG_W-1:0]  cfg_data_i
);
  import arkf_pkg::*;

  logic [CFG_W-1:0] q_angle_q, q_rate_q, r_meas_q;
  logic             cmd_valid, cmd_ready;
  cmd_t             cmd;
  mul_req_t         mul_req;
  mul_rsp_t         mul_rsp;
  div_req_t         div_req;
  div_rsp_t         div_rsp;

  // Writes to an index beyond the register list are accepted and dropped.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      q_angle_q <= Q_ANGLE_RST;
      q_rate_q  <= Q_RATE_RST;
      r_meas_q  <= R_MEAS_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_Q_ANGLE: q_angle_q <= cfg_data_i;
        CFG_Q_RATE:  q_rate_q  <= cfg_data_i;
        CFG_R_MEAS:  r_meas_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  arkf_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .cmd_valid_o (cmd_valid),
    .cmd_ready_i (cmd_ready),
    .cmd_o       (cmd)
  );

  arkf_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .rsp_o  (mul_rsp)
  );

  arkf_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  arkf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_ready_o (cmd_ready),
    .cmd_i       (cmd),
    .q_angle_i   (q_angle_q),
    .q_rate_i    (q_rate_q),
    .r_meas_i    (r_meas_q),
    .mul_req_o   (mul_req),
    .mul_rsp_i   (mul_rsp),
    .div_req_o   (div_req),
    .div_rsp_i   (div_rsp),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  // The sequencer never runs the multiplier and the divider at once.
  a_one_unit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mul_req.start && div_req.start))
    else $error("multiplier and divider started together");

  // A product is never reported in the cycle right after its start.
  a_mul_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_req.start |=> !mul_rsp.done)
    else $error("multiplier finished too early");

  // The core takes a queued item only while no unit is being started.
  a_pop_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_valid && cmd_ready) |-> !(mul_req.start || div_req.start))
    else $error("item taken while a unit was started");

endmodule
